FILE: rtl/core/ocfm_pkg.sv
// Shared types, codes and constants for the oxygen cell frame monitor.
`default_nettype none
package ocfm_pkg;

  localparam int CELLS_MAX   = 3;
  localparam int CELL_COUNT_DEF = 3;
  localparam int AGE_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
  localparam logic [7:0] BYTE_FAIL = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PPO2_TYPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_TYPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_EN      = 3'd4;

  localparam logic [4:0]  CHANNEL_ID_RST  = 5'd13;
  localparam logic [7:0]  PPO2_TYPE_RST   = 8'd4;
  localparam logic [7:0]  STATUS_TYPE_RST = 8'd202;
  localparam logic [15:0] LOST_TMO_RST    = 16'd1000;

  // cell conditions
  localparam logic [1:0] COND_OK    = 2'd0;
  localparam logic [1:0] COND_VOTED = 2'd1;
  localparam logic [1:0] COND_FAIL  = 2'd2;

  // classified operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_PPO2   = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [7:0]  payload_byte0;
    logic [7:0]  payload_byte1;
    logic [7:0]  payload_byte2;
    logic [7:0]  payload_byte3;
  } in_t;

  typedef struct packed {
    logic [1:0] cell0_status;
    logic [1:0] cell1_status;
    logic [1:0] cell2_status;
    logic [7:0] cell0_reading;
    logic [7:0] cell1_reading;
    logic [7:0] cell2_reading;
    logic [7:0] consensus_reading;
    logic       consensus_valid;
    logic       bus_lost;
    logic       frame_recognised;
  } out_t;

  typedef struct packed {
    logic [1:0] op;
    logic       len_ok;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } op_t;

  typedef struct packed {
    logic [4:0]  channel_id;
    logic [7:0]  ppo2_msg_type;
    logic [7:0]  status_msg_type;
    logic [15:0] lost_timeout_ms;
    logic        bus_enabled;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/ocfm_front.sv
// Front end: splits the identifier and classifies each incoming word.
`default_nettype none
module ocfm_front
  import ocfm_pkg::*;
(
  input  wire cfg_t cfg,
  input  wire in_t  in_data,
  output op_t       op
);

  logic [4:0] chan;
  logic [7:0] mtype;

  assign chan  = in_data.frame_id[28:24];
  assign mtype = in_data.frame_id[23:16];

  always_comb begin
    op.b0     = in_data.payload_byte0;
    op.b1     = in_data.payload_byte1;
    op.b2     = in_data.payload_byte2;
    op.b3     = in_data.payload_byte3;
    op.op     = OP_NONE;
    op.len_ok = 1'b0;
    if (in_data.kind) begin
      op.op = OP_TICK;
    end else if (chan == cfg.channel_id) begin
      // equal type codes resolve to ppo2
      if (mtype == cfg.ppo2_msg_type) begin
        op.op     = OP_PPO2;
        op.len_ok = (in_data.frame_length >= 4'd4);
      end else if (mtype == cfg.status_msg_type) begin
        op.op     = OP_STATUS;
        op.len_ok = (in_data.frame_length >= 4'd2);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ocfm_queue.sv
// Two-entry queue between the classifier and the state update.
`default_nettype none
module ocfm_queue
  import ocfm_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       push,
  input  wire op_t  push_data,
  output logic      full,
  input  wire       pop,
  output logic      not_empty,
  output op_t       pop_data
);

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ocfm_back.sv
// Back end: applies classified words to cell state and registers the result word.
`default_nettype none
module ocfm_back
  import ocfm_pkg::*;
#(
  parameter int CELL_COUNT = CELL_COUNT_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire cfg_t cfg,
  input  wire       q_valid,
  input  wire op_t  q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  wire       out_ready,
  output out_t      out_data
);

  logic [1:0]       cond_r  [CELLS_MAX];
  logic [1:0]       cond_nxt[CELLS_MAX];
  logic [7:0]       press_r  [CELLS_MAX];
  logic [7:0]       press_nxt[CELLS_MAX];
  logic [7:0]       cons_r, cons_nxt;
  logic             seen_r, seen_nxt;
  logic             heard_r, heard_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             recog;
  logic             lost;
  logic             out_valid_r;
  out_t             out_r, out_nxt;
  logic [7:0]       raw [CELLS_MAX];

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign raw[0] = q_data.b1;
  assign raw[1] = q_data.b2;
  assign raw[2] = q_data.b3;

  always_comb begin
    for (int i = 0; i < CELLS_MAX; i++) begin
      cond_nxt[i]  = cond_r[i];
      press_nxt[i] = press_r[i];
    end
    cons_nxt  = cons_r;
    seen_nxt  = seen_r;
    heard_nxt = heard_r;
    age_nxt   = age_r;
    recog     = (q_data.op == OP_PPO2) || (q_data.op == OP_STATUS);

    case (q_data.op)
      OP_TICK: begin
        if (age_r != AGE_MAX) begin
          age_nxt = age_r + 1'b1;
        end
      end
      OP_PPO2: begin
        if (q_data.len_ok) begin
          for (int i = 0; i < CELLS_MAX; i++) begin
            if (i < CELL_COUNT) begin
              if (raw[i] == BYTE_FAIL) begin
                cond_nxt[i] = COND_FAIL;
              end else begin
                press_nxt[i] = raw[i];
                if (cond_r[i] == COND_FAIL) cond_nxt[i] = COND_OK;
              end
            end
          end
        end
      end
      OP_STATUS: begin
        if (q_data.len_ok) begin
          for (int i = 0; i < CELLS_MAX; i++) begin
            if (i < CELL_COUNT && cond_r[i] != COND_FAIL) begin
              cond_nxt[i] = q_data.b0[i] ? COND_OK : COND_VOTED;
            end
          end
          cons_nxt = q_data.b1;
          seen_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    if (recog) begin
      age_nxt   = '0;
      heard_nxt = 1'b1;
    end

    lost = cfg.bus_enabled && (!heard_nxt || (age_nxt > {1'b0, cfg.lost_timeout_ms}));

    out_nxt.cell0_status      = cond_nxt[0];
    out_nxt.cell1_status      = cond_nxt[1];
    out_nxt.cell2_status      = cond_nxt[2];
    out_nxt.cell0_reading     = press_nxt[0];
    out_nxt.cell1_reading     = press_nxt[1];
    out_nxt.cell2_reading     = press_nxt[2];
    out_nxt.consensus_reading = cons_nxt;
    out_nxt.consensus_valid   = seen_nxt;
    out_nxt.bus_lost          = lost;
    out_nxt.frame_recognised  = recog;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS_MAX; i++) begin
        cond_r[i]  <= COND_OK;
        press_r[i] <= '0;
      end
      cons_r      <= '0;
      seen_r      <= 1'b0;
      heard_r     <= 1'b0;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        for (int i = 0; i < CELLS_MAX; i++) begin
          cond_r[i]  <= cond_nxt[i];
          press_r[i] <= press_nxt[i];
        end
        cons_r      <= cons_nxt;
        seen_r      <= seen_nxt;
        heard_r     <= heard_nxt;
        age_r       <= age_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/oxygen_cell_frame_monitor.sv
// Top level of the oxygen cell frame monitor: register file, classifier, queue, update.
//
//   port group   dir   handshake            word
//   in_*         in    in_valid/in_ready    in_t: frame or millisecond tick
//   out_*        out   out_valid/out_ready  out_t: cell state after the word
//   cfg_*        in    cfg_valid/cfg_ready  register index and data
//
// One word per cycle while out_ready holds; a taken word is written into the queue,
// then popped, applied to the cell state and the result written to the result register.
// Sync active-low reset: register defaults, cell state and queue cleared; no clearing pass.
// A stall on out_ready fills the result register, then the queue, then drops in_ready.
// cfg_ready is always high.
`default_nettype none
module oxygen_cell_frame_monitor
  import ocfm_pkg::*;
#(
  parameter int CELL_COUNT = CELL_COUNT_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire in_t             in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output out_t                 out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  op_t  front_op;
  op_t  q_data;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_id      <= CHANNEL_ID_RST;
      cfg_r.ppo2_msg_type   <= PPO2_TYPE_RST;
      cfg_r.status_msg_type <= STATUS_TYPE_RST;
      cfg_r.lost_timeout_ms <= LOST_TMO_RST;
      cfg_r.bus_enabled     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNEL_ID:  cfg_r.channel_id      <= cfg_data[4:0];
        CFG_PPO2_TYPE:   cfg_r.ppo2_msg_type   <= cfg_data[7:0];
        CFG_STATUS_TYPE: cfg_r.status_msg_type <= cfg_data[7:0];
        CFG_LOST_TMO:    cfg_r.lost_timeout_ms <= cfg_data;
        CFG_BUS_EN:      cfg_r.bus_enabled     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ocfm_front u_front (
    .cfg     (cfg_r),
    .in_data (in_data),
    .op      (front_op)
  );

  ocfm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  ocfm_back #(
    .CELL_COUNT (CELL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
